/* hw/rtl/dcsd_pkg.sv */
`timescale 1ns / 1ps

package dcsd_pkg;

   // Largest number of points; the store, the counted map and the row sums are sized by it.
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int N_W        = $clog2(MAX_POINTS + 1);

   // Field widths of the ports.
   localparam int KIND_W = 2;
   localparam int RC_W   = 6;
   localparam int DISS_W = 16;
   localparam int PC_W   = 7;
   localparam int OUT_W  = 33;

   // Squares are Q16.16; per doubling of points a row sum gains one bit, the total two.
   localparam int SQ_W  = 2 * DISS_W;
   localparam int ROW_W = SQ_W + IDX_W;
   localparam int TOT_W = SQ_W + 2 * IDX_W;
   localparam int DVS_W = 2 * N_W;

   localparam logic [PC_W-1:0] PC_RESET = PC_W'(64);

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      logic capture;
      logic sweep_step;
      logic total_clear;
      logic ld_read;
      logic ld_write;
      logic rd_fetch_row;
      logic rd_fetch_col;
      logic div_start;
      logic div_total;
      logic cap_a;
      logic cap_b;
      logic cap_t;
      logic sum_step;
      logic emit;
      logic emit_zero;
   } dcsd_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic div_done;
      logic req_in_range;
   } dcsd_status_type;

endpackage

/* hw/rtl/double_center_squared_distances.sv */
`timescale 1ns / 1ps

// Double centering of a squared dissimilarity matrix for classical scaling.
// Items enter on start while busy is low: kind, row, col and dissimilarity (Q8.8).
// A load item stores the square of the dissimilarity and updates the row sum and
// the total when row and col differ; busy stays high until the store is written.
// A clear item zeroes all sums and the counted map in a pass over the MAX_POINTS rows
// (64 here), one row per cycle, with busy high throughout.
// A read item gives one result, -0.5 * (d2 - rowsum_i/n - rowsum_j/n + total/n^2),
// on rsp_cross_value (signed Q16.16), marked by rsp_valid for one cycle. The three
// divisions, two by the point count and one by its square, run one after another
// through a single restoring divider.
// A read with an index of MAX_POINTS or more skips the divisions and answers zero.
// The point count is to be written on the csr_ channel only while the block is idle;
// the block leaves this to the user, as csr_ready is tied high. After reset the
// same clearing pass runs before the first item is accepted, and the point count
// returns to 64. Results cannot be held off: each is shown for exactly one cycle.

module double_center_squared_distances (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dcsd_pkg::KIND_W-1:0]       req_kind,
   input  logic [dcsd_pkg::RC_W-1:0]         req_row,
   input  logic [dcsd_pkg::RC_W-1:0]         req_col,
   input  logic [dcsd_pkg::DISS_W-1:0]       req_dissimilarity,
   output logic                              rsp_valid,
   output logic signed [dcsd_pkg::OUT_W-1:0] rsp_cross_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dcsd_pkg::PC_W-1:0]         csr_point_count
);
   import dcsd_pkg::*;

   dcsd_cmd_type    cmd;
   dcsd_status_type status;

   assign csr_ready = 1'b1;

   dcsd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (kind_type'(req_kind)),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   dcsd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_dissimilarity (req_dissimilarity),
      .csr_write         (csr_valid & csr_ready),
      .csr_point_count   (csr_point_count),
      .rsp_valid         (rsp_valid),
      .rsp_cross_value   (rsp_cross_value)
   );

endmodule

/* hw/rtl/dcsd_div.sv */
`timescale 1ns / 1ps

module dcsd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dcsd_pkg::TOT_W-1:0]   dividend,
   input  logic [dcsd_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [dcsd_pkg::TOT_W-1:0]   quotient
);
   import dcsd_pkg::*;

   localparam int CNT_W = $clog2(TOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOT_W - 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOT_W-1:0]   quo_ff, quo_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W:0]     trial;
   logic [DVS_W:0]     diff;
   logic               fits;

   // Restoring division, one quotient bit per cycle, dividend shifted out at the top.
   always_comb begin
      trial = {rem_ff, quo_ff[TOT_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[TOT_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/dcsd_datapath.sv */
`timescale 1ns / 1ps

module dcsd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dcsd_pkg::dcsd_cmd_type            cmd,
   output dcsd_pkg::dcsd_status_type         status,
   input  logic [dcsd_pkg::RC_W-1:0]         req_row,
   input  logic [dcsd_pkg::RC_W-1:0]         req_col,
   input  logic [dcsd_pkg::DISS_W-1:0]       req_dissimilarity,
   input  logic                              csr_write,
   input  logic [dcsd_pkg::PC_W-1:0]         csr_point_count,
   output logic                              rsp_valid,
   output logic signed [dcsd_pkg::OUT_W-1:0] rsp_cross_value
);
   import dcsd_pkg::*;

   localparam int STORE_DEPTH = 1 << (2 * IDX_W);
   localparam int P_W = TOT_W + 1;
   localparam int S_W = TOT_W + 2;
   localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_POINTS - 1);
   localparam logic signed [S_W-1:0] SAT_HI =
      {{(S_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic signed [S_W-1:0] SAT_LO =
      {{(S_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

   // Memories.
   logic [SQ_W-1:0]       store_mem [STORE_DEPTH];
   logic [MAX_POINTS-1:0] cnt_mem   [MAX_POINTS];
   logic [ROW_W-1:0]      rs_mem    [MAX_POINTS];

   // Item and working registers.
   logic [IDX_W-1:0]      row_ff, col_ff;
   logic [DISS_W-1:0]     diss_ff;
   logic [SQ_W-1:0]       sq_ff;
   logic [SQ_W-1:0]       store_q_ff;
   logic [MAX_POINTS-1:0] cnt_q_ff;
   logic [ROW_W-1:0]      rs_q_ff;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [PC_W-1:0]       point_count_ff;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [DVS_W-1:0]      nsq_ff;
   logic [ROW_W-1:0]      a_ff, b_ff;
   logic [TOT_W-1:0]      t_ff;
   logic signed [S_W-1:0] s_ff;
   logic                  rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_value_ff, rsp_value_in;

   logic [N_W-1:0]        n_eff;
   logic                  off_diag;
   logic [SQ_W-1:0]       old_sq;
   logic [STORE_DEPTH > 1 ? 2*IDX_W-1 : 0:0] store_addr;
   logic                  store_re;
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [MAX_POINTS-1:0] cnt_wdata;
   logic [MAX_POINTS-1:0] cnt_set;
   logic                  rs_we, rs_re;
   logic [IDX_W-1:0]      rs_waddr, rs_raddr;
   logic [ROW_W-1:0]      rs_wdata;
   logic [TOT_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic                  div_done;
   logic [TOT_W-1:0]      div_quotient;
   logic [SQ_W-1:0]       d2;
   logic [P_W-1:0]        pos_sum, neg_sum;
   logic signed [S_W-1:0] neg_s, half;

   assign status.req_in_range = (int'(req_row) < MAX_POINTS) && (int'(req_col) < MAX_POINTS);
   assign status.sweep_last   = (sweep_ff == SWEEP_LAST);
   assign status.div_done     = div_done;

   // A point count of zero counts as one, and one above the maximum as the maximum.
   always_comb begin
      if (point_count_ff == '0) begin
         n_eff = N_W'(1);
      end else if (int'(point_count_ff) > MAX_POINTS) begin
         n_eff = N_W'(MAX_POINTS);
      end else begin
         n_eff = N_W'(point_count_ff);
      end
   end

   always_comb begin
      off_diag   = (row_ff != col_ff);
      old_sq     = cnt_q_ff[col_ff] ? store_q_ff : '0;
      store_addr = {row_ff, col_ff};
      store_re   = cmd.ld_read | cmd.rd_fetch_row;
      cnt_set    = '0;
      cnt_set[col_ff] = 1'b1;

      cnt_we    = cmd.sweep_step | (cmd.ld_write & off_diag);
      cnt_waddr = cmd.sweep_step ? sweep_ff : row_ff;
      cnt_wdata = cmd.sweep_step ? '0 : (cnt_q_ff | cnt_set);

      rs_we    = cmd.sweep_step | (cmd.ld_write & off_diag);
      rs_waddr = cmd.sweep_step ? sweep_ff : row_ff;
      rs_wdata = cmd.sweep_step ? '0 :
                 (rs_q_ff - ROW_W'(old_sq) + ROW_W'(sq_ff));
      rs_re    = cmd.ld_read | cmd.rd_fetch_row | cmd.rd_fetch_col;
      rs_raddr = cmd.rd_fetch_col ? col_ff : row_ff;

      total_in = total_ff;
      if (cmd.total_clear) begin
         total_in = '0;
      end else if (cmd.ld_write & off_diag) begin
         total_in = total_ff - TOT_W'(old_sq) + TOT_W'(sq_ff);
      end

      sweep_in = sweep_ff;
      if (cmd.sweep_step) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (store_re) begin
         store_q_ff <= store_mem[store_addr];
      end
      if (cmd.ld_write) begin
         store_mem[store_addr] <= sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_read) begin
         cnt_q_ff <= cnt_mem[row_ff];
      end
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rs_re) begin
         rs_q_ff <= rs_mem[rs_raddr];
      end
      if (rs_we) begin
         rs_mem[rs_waddr] <= rs_wdata;
      end
   end

   // The first division takes the row sum, the second the column sum, the third
   // the total over the square of the point count.
   always_comb begin
      div_dividend = cmd.div_total ? total_ff : TOT_W'(rs_q_ff);
      div_divisor  = cmd.div_total ? nsq_ff : DVS_W'(n_eff);
   end

   dcsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      d2      = off_diag ? store_q_ff : '0;
      pos_sum = P_W'(t_ff) + P_W'(d2);
      neg_sum = P_W'(a_ff) + P_W'(b_ff);
      neg_s   = -s_ff;
      half    = neg_s >>> 1;
      if (cmd.emit_zero) begin
         rsp_value_in = '0;
      end else if (half > SAT_HI) begin
         rsp_value_in = SAT_HI[OUT_W-1:0];
      end else if (half < SAT_LO) begin
         rsp_value_in = SAT_LO[OUT_W-1:0];
      end else begin
         rsp_value_in = half[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff  <= IDX_W'(req_row);
         col_ff  <= IDX_W'(req_col);
         diss_ff <= req_dissimilarity;
      end
      if (cmd.ld_read) begin
         sq_ff <= SQ_W'(diss_ff) * SQ_W'(diss_ff);
      end
      if (cmd.rd_fetch_row) begin
         nsq_ff <= DVS_W'(n_eff) * DVS_W'(n_eff);
      end
      if (cmd.cap_a) begin
         a_ff <= div_quotient[ROW_W-1:0];
      end
      if (cmd.cap_b) begin
         b_ff <= div_quotient[ROW_W-1:0];
      end
      if (cmd.cap_t) begin
         t_ff <= div_quotient;
      end
      if (cmd.sum_step) begin
         s_ff <= $signed(S_W'(pos_sum)) - $signed(S_W'(neg_sum));
      end
      if (cmd.emit | cmd.emit_zero) begin
         rsp_value_ff <= rsp_value_in;
      end
      total_ff <= total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= PC_RESET;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            point_count_ff <= csr_point_count;
         end
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= cmd.emit | cmd.emit_zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cross_value = rsp_value_ff;

endmodule

/* hw/rtl/dcsd_ctrl.sv */
`timescale 1ns / 1ps

module dcsd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  dcsd_pkg::kind_type         req_kind,
   input  dcsd_pkg::dcsd_status_type  status,
   output dcsd_pkg::dcsd_cmd_type     cmd,
   output logic                       busy
);
   import dcsd_pkg::*;

   typedef enum logic [11:0] {
      ST_SWEEP   = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_LD_READ = 12'b0000_0000_0100,
      ST_LD_WRITE= 12'b0000_0000_1000,
      ST_RD_ZERO = 12'b0000_0001_0000,
      ST_RD_FETCH= 12'b0000_0010_0000,
      ST_RD_START= 12'b0000_0100_0000,
      ST_RD_DIV_A= 12'b0000_1000_0000,
      ST_RD_DIV_B= 12'b0001_0000_0000,
      ST_RD_DIV_T= 12'b0010_0000_0000,
      ST_RD_SUM  = 12'b0100_0000_0000,
      ST_RD_OUT  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step  = 1'b1;
            cmd.total_clear = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  KIND_CLEAR: begin
                     state_in = ST_SWEEP;
                  end
                  KIND_LOAD: begin
                     state_in = status.req_in_range ? ST_LD_READ : ST_IDLE;
                  end
                  KIND_READ: begin
                     state_in = status.req_in_range ? ST_RD_FETCH : ST_RD_ZERO;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LD_READ: begin
            cmd.ld_read = 1'b1;
            state_in    = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            cmd.ld_write = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RD_ZERO: begin
            cmd.emit_zero = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_RD_FETCH: begin
            cmd.rd_fetch_row = 1'b1;
            state_in         = ST_RD_START;
         end
         ST_RD_START: begin
            // The divider takes the row sum at this edge while the column sum is fetched.
            cmd.div_start    = 1'b1;
            cmd.rd_fetch_col = 1'b1;
            state_in         = ST_RD_DIV_A;
         end
         ST_RD_DIV_A: begin
            if (status.div_done) begin
               cmd.cap_a     = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_RD_DIV_B;
            end
         end
         ST_RD_DIV_B: begin
            if (status.div_done) begin
               cmd.cap_b     = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_total = 1'b1;
               state_in      = ST_RD_DIV_T;
            end
         end
         ST_RD_DIV_T: begin
            if (status.div_done) begin
               cmd.cap_t = 1'b1;
               state_in  = ST_RD_SUM;
            end
         end
         ST_RD_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
